// File: hw/rtl/bmpp_pkg.sv
package bmpp_pkg;

  localparam int RES_DEPTH_DEF = 4;

  localparam logic [31:0] HEADER_BYTES = 32'd54;
  localparam logic [31:0] HEADER_LAST  = 32'd53;
  localparam logic [31:0] POS_MAX      = 32'hffff_ffff;

  localparam logic [31:0] SIZE_FIRST   = 32'd2;
  localparam logic [31:0] SIZE_LAST    = 32'd5;
  localparam logic [31:0] OFFSET_FIRST = 32'd10;
  localparam logic [31:0] OFFSET_LAST  = 32'd13;
  localparam logic [31:0] WIDTH_FIRST  = 32'd18;
  localparam logic [31:0] WIDTH_LAST   = 32'd21;
  localparam logic [31:0] HEIGHT_FIRST = 32'd22;
  localparam logic [31:0] HEIGHT_LAST  = 32'd25;
  localparam logic [31:0] DEPTH_FIRST  = 32'd28;
  localparam logic [31:0] DEPTH_LAST   = 32'd29;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_OFFSET = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] file_size;
    logic [31:0] data_offset;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [15:0] bits_per_pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic first_vld;
    logic second_vld;
    res_t first;
    res_t second;
  } res_wr_t;

  function automatic logic [31:0] put_byte(input logic [31:0] f, input logic [1:0] lane,
                                           input logic [7:0] d);
    logic [31:0] r;
    r = f;
    r[{lane, 3'b000} +: 8] = d;
    return r;
  endfunction

endpackage

// File: hw/rtl/bmpp_in_if.sv
interface bmpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: hw/rtl/bmpp_out_if.sv
interface bmpp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [31:0] file_size;
  logic [31:0] data_offset;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [15:0] bits_per_pixel;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        run_end;

  modport source (output valid, output kind, output status, output file_size,
                  output data_offset, output image_width, output image_height,
                  output bits_per_pixel, output red, output green, output blue,
                  output run_end, input ready);
  modport sink (input valid, input kind, input status, input file_size,
                input data_offset, input image_width, input image_height,
                input bits_per_pixel, input red, input green, input blue,
                input run_end, output ready);
endinterface

// File: hw/rtl/bmpp_core.sv
module bmpp_core
  import bmpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output res_wr_t    wr
);

  logic [31:0] pos_r, pos_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [33:0] w3_r, w3_nxt;
  logic [33:0] rbc_r, rbc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        oerr_r, oerr_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;

  logic [31:0] dep32;
  logic [33:0] rbc_inc;
  logic        oerr_now;
  logic        main_vld;
  res_t        main_res;
  res_t        done_res;

  always_comb begin
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    w3_nxt     = w3_r;
    rbc_nxt    = rbc_r;
    pad_nxt    = pad_r;
    phase_nxt  = phase_r;
    oerr_nxt   = oerr_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    dep32      = put_byte({16'd0, depth_r}, pos_r[1:0], data_byte);
    rbc_inc    = rbc_r + 34'd3;
    oerr_now   = oerr_r;
    main_vld   = 1'b0;
    main_res   = '0;
    done_res   = '0;
    wr         = '0;

    if (in_fire) begin
      pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 32'd1;

      priority if (pos_r >= SIZE_FIRST && pos_r <= SIZE_LAST) begin
        size_nxt = put_byte(size_r, pos_r[1:0] - 2'd2, data_byte);
      end else if (pos_r >= OFFSET_FIRST && pos_r <= OFFSET_LAST) begin
        offset_nxt = put_byte(offset_r, pos_r[1:0] - 2'd2, data_byte);
      end else if (pos_r >= WIDTH_FIRST && pos_r <= WIDTH_LAST) begin
        width_nxt = put_byte(width_r, pos_r[1:0] - 2'd2, data_byte);
      end else if (pos_r >= HEIGHT_FIRST && pos_r <= HEIGHT_LAST) begin
        height_nxt = put_byte(height_r, pos_r[1:0] - 2'd2, data_byte);
      end else if (pos_r >= DEPTH_FIRST && pos_r <= DEPTH_LAST) begin
        depth_nxt = dep32[15:0];
      end else begin
        depth_nxt = depth_r;
      end

      if (pos_r == HEADER_LAST) begin
        oerr_now                = (offset_r < HEADER_BYTES);
        oerr_nxt                = oerr_now;
        // precompute row length in bytes for the pixel phase
        w3_nxt                  = {2'b00, width_r} + {1'b0, width_r, 1'b0};
        main_vld                = 1'b1;
        main_res.kind           = KIND_HEADER;
        main_res.file_size      = size_r;
        main_res.data_offset    = offset_r;
        main_res.image_width    = width_r;
        main_res.image_height   = height_r;
        main_res.bits_per_pixel = depth_r;
      end else if (pos_r >= HEADER_BYTES && !oerr_r && pos_r >= offset_r) begin
        if (pad_r != 2'd0) begin
          pad_nxt = pad_r - 2'd1;
        end else begin
          unique case (phase_r)
            PH_BLUE: begin
              blue_nxt  = data_byte;
              phase_nxt = PH_GREEN;
            end
            PH_GREEN: begin
              green_nxt = data_byte;
              phase_nxt = PH_RED;
            end
            default: begin
              main_vld       = 1'b1;
              main_res.kind  = KIND_PIXEL;
              main_res.red   = data_byte;
              main_res.green = green_r;
              main_res.blue  = blue_r;
              phase_nxt      = PH_BLUE;
              if (width_r != 32'd0) begin
                if (rbc_inc == w3_r) begin
                  // skip padding up to the next multiple of four
                  pad_nxt = 2'd0 - rbc_inc[1:0];
                  rbc_nxt = '0;
                end else begin
                  rbc_nxt = rbc_inc;
                end
              end
            end
          endcase
        end
      end

      if (final_byte) begin
        done_res.kind = KIND_DONE;
        priority if (pos_r < HEADER_LAST) begin
          done_res.status = ST_SHORT;
        end else if (oerr_now) begin
          done_res.status = ST_OFFSET;
        end else begin
          done_res.status = ST_OK;
        end
        // return to reset so the next byte opens a new file
        pos_nxt    = '0;
        size_nxt   = '0;
        offset_nxt = '0;
        width_nxt  = '0;
        height_nxt = '0;
        depth_nxt  = '0;
        w3_nxt     = '0;
        rbc_nxt    = '0;
        pad_nxt    = '0;
        phase_nxt  = PH_BLUE;
        oerr_nxt   = 1'b0;
      end

      done_res.run_end = 1'b1;
      main_res.run_end = !final_byte;
      if (main_vld) begin
        wr.first_vld  = 1'b1;
        wr.first      = main_res;
        wr.second_vld = final_byte;
        wr.second     = done_res;
      end else begin
        wr.first_vld  = final_byte;
        wr.first      = done_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      size_r   <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      w3_r     <= '0;
      rbc_r    <= '0;
      pad_r    <= '0;
      phase_r  <= PH_BLUE;
      oerr_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      size_r   <= size_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      w3_r     <= w3_nxt;
      rbc_r    <= rbc_nxt;
      pad_r    <= pad_nxt;
      phase_r  <= phase_nxt;
      oerr_r   <= oerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
  end

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && final_byte |=> pos_r == 32'd0 && phase_r == PH_BLUE && !oerr_r)
    else $error("parser state not cleared after final byte");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    wr.second_vld |-> wr.first_vld && wr.first.kind != KIND_DONE)
    else $error("second result without a leading header or pixel");

  a_pixel_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    wr.first_vld && wr.first.kind == KIND_PIXEL |-> !oerr_r && pos_r >= HEADER_BYTES)
    else $error("pixel emitted inside header or after offset error");
`endif

endmodule

// File: hw/rtl/bmpp_res_fifo.sv
module bmpp_res_fifo
  import bmpp_pkg::*;
#(
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  res_wr_t wr,
  output logic    room2,
  output logic    rd_valid,
  input  logic    rd_ready,
  output res_t    rd_data
);

  localparam int PW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int CW = $clog2(RES_DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(RES_DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(RES_DEPTH - 2);
  localparam logic [CW-1:0] FULL_CNT = CW'(RES_DEPTH);

  res_t          mem_r [RES_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, wp1, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign room2    = (cnt_r <= ROOM_MAX);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign pop      = rd_valid && rd_ready;
  assign wp1      = bump(wp_r);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr.first_vld) begin
      wp_nxt = wr.second_vld ? bump(wp1) : wp1;
    end
    if (pop) begin
      rp_nxt = bump(rp_r);
    end
    cnt_nxt = cnt_r + CW'(wr.first_vld) + CW'(wr.second_vld) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.first_vld) begin
      mem_r[wp_r] <= wr.first;
    end
    if (wr.second_vld) begin
      mem_r[wp1] <= wr.second;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("result queue count beyond depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.first_vld |-> cnt_r <= ROOM_MAX)
    else $error("result written without two free entries");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    !wr.first_vld && !pop |=> $stable(cnt_r))
    else $error("queue count moved without push or pop");
`endif

endmodule

// File: hw/rtl/bmp_pixel_stream_parser.sv
// A byte's results enter the result queue as it is accepted; out_bus offers the queue head.
// Throughput: one byte per cycle while the queue has two free entries; a byte that yields a
//   header or pixel plus the end-of-file status writes two results into the queue.
// in_bus.ready holds while the result queue has two free entries (RES_DEPTH deep).
// Reset: rst_n is synchronous, active low; it clears the parser state and empties the queue.
module bmp_pixel_stream_parser
  import bmpp_pkg::*;
#(
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  bmpp_in_if.sink          in_bus,
  bmpp_out_if.source       out_bus
);

  res_wr_t wr;
  res_t    head;
  logic    room2;
  logic    in_fire;

  assign in_bus.ready = room2;
  assign in_fire      = in_bus.valid && room2;

  bmpp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_bus.data_byte),
    .final_byte (in_bus.final_byte),
    .wr         (wr)
  );

  bmpp_res_fifo #(
    .RES_DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .room2    (room2),
    .rd_valid (out_bus.valid),
    .rd_ready (out_bus.ready),
    .rd_data  (head)
  );

  assign out_bus.kind           = head.kind;
  assign out_bus.status         = head.status;
  assign out_bus.file_size      = head.file_size;
  assign out_bus.data_offset    = head.data_offset;
  assign out_bus.image_width    = head.image_width;
  assign out_bus.image_height   = head.image_height;
  assign out_bus.bits_per_pixel = head.bits_per_pixel;
  assign out_bus.red            = head.red;
  assign out_bus.green          = head.green;
  assign out_bus.blue           = head.blue;
  assign out_bus.run_end        = head.run_end;

endmodule

// File: tb/tb_bmp_pixel_stream_parser.sv
`timescale 1ns / 100ps

module tb_bmp_pixel_stream_parser;
  import bmpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENT_BYTES  = 150;
  localparam int NUM_SEGMENTS   = 8;
  localparam int IDLE_PCT[4]  = '{0, 63, 0, 21};
  localparam int STALL_PCT[4] = '{0, 0, 63, 21};

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_req_t;

  logic clk;
  logic rst_n;

  bmpp_in_if  in_bus ();
  bmpp_out_if out_bus ();

  bmp_pixel_stream_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  byte_req_t  pend_q[$];
  res_t       exp_results[$];
  logic [7:0] file_buf[$];
  byte_req_t  drv_req;

  int   idle_pct;
  int   stall_pct;
  int   err_count;
  int   idle_cycles;
  int   bytes_queued;
  logic in_taken;
  logic out_taken;

  // Shadow copy of the parser state
  logic [31:0] pos_cnt;
  logic [31:0] sz_f;
  logic [31:0] off_f;
  logic [31:0] wid_f;
  logic [31:0] hgt_f;
  logic [15:0] bpp_f;
  logic [33:0] row_cnt;
  logic [1:0]  pad_left;
  logic [15:0] held_px;
  phase_t      px_phase;
  logic        off_bad;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] ins_byte(input logic [31:0] f, input logic [31:0] rel,
                                           input logic [7:0] d);
    logic [31:0] sh;
    sh = {27'd0, rel[1:0], 3'd0};
    return (f & ~(32'h0000_00ff << sh)) | ({24'd0, d} << sh);
  endfunction

  task automatic clear_parser();
    pos_cnt  = '0;
    sz_f     = '0;
    off_f    = '0;
    wid_f    = '0;
    hgt_f    = '0;
    bpp_f    = '0;
    row_cnt  = '0;
    pad_left = '0;
    held_px  = '0;
    px_phase = PH_BLUE;
    off_bad  = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] d, input logic fin);
    logic [31:0] idx;
    logic [31:0] tmp;
    res_t        r;
    res_t        new_res[$];
    idx = pos_cnt;
    if (pos_cnt != POS_MAX) pos_cnt = pos_cnt + 1;

    if (idx >= SIZE_FIRST && idx <= SIZE_LAST) begin
      sz_f = ins_byte(sz_f, idx - SIZE_FIRST, d);
    end else if (idx >= OFFSET_FIRST && idx <= OFFSET_LAST) begin
      off_f = ins_byte(off_f, idx - OFFSET_FIRST, d);
    end else if (idx >= WIDTH_FIRST && idx <= WIDTH_LAST) begin
      wid_f = ins_byte(wid_f, idx - WIDTH_FIRST, d);
    end else if (idx >= HEIGHT_FIRST && idx <= HEIGHT_LAST) begin
      hgt_f = ins_byte(hgt_f, idx - HEIGHT_FIRST, d);
    end else if (idx >= DEPTH_FIRST && idx <= DEPTH_LAST) begin
      tmp   = ins_byte({16'd0, bpp_f}, idx - DEPTH_FIRST, d);
      bpp_f = tmp[15:0];
    end

    if (idx == HEADER_LAST) begin
      off_bad          = (off_f < HEADER_BYTES);
      r                = '0;
      r.kind           = KIND_HEADER;
      r.file_size      = sz_f;
      r.data_offset    = off_f;
      r.image_width    = wid_f;
      r.image_height   = hgt_f;
      r.bits_per_pixel = bpp_f;
      new_res.insert(new_res.size(), r);
    end else if (idx >= HEADER_BYTES && !off_bad && idx >= off_f) begin
      if (pad_left != 2'd0) begin
        pad_left = pad_left - 2'd1;
      end else if (px_phase == PH_BLUE) begin
        held_px  = {8'h00, d};
        px_phase = PH_GREEN;
      end else if (px_phase == PH_GREEN) begin
        held_px[15:8] = d;
        px_phase      = PH_RED;
      end else begin
        r        = '0;
        r.kind   = KIND_PIXEL;
        r.red    = d;
        r.green  = held_px[15:8];
        r.blue   = held_px[7:0];
        new_res.insert(new_res.size(), r);
        px_phase = PH_BLUE;
        held_px  = '0;
        // row tracking only when a width is given
        if (wid_f != 32'd0) begin
          row_cnt = row_cnt + 34'd3;
          if (row_cnt == {2'b00, wid_f} * 34'd3) begin
            pad_left = 2'd0 - row_cnt[1:0];
            row_cnt  = '0;
          end
        end
      end
    end

    if (fin) begin
      r      = '0;
      r.kind = KIND_DONE;
      if (idx < HEADER_LAST) r.status = ST_SHORT;
      else if (off_bad) r.status = ST_OFFSET;
      else r.status = ST_OK;
      new_res.insert(new_res.size(), r);
      clear_parser();
    end

    if (new_res.size() != 0) new_res[new_res.size() - 1].run_end = 1'b1;
    foreach (new_res[i]) exp_results.insert(exp_results.size(), new_res[i]);
  endtask

  task automatic report_mismatch(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, name, got, want);
      err_count++;
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.kind           = out_bus.kind;
    got.status         = out_bus.status;
    got.file_size      = out_bus.file_size;
    got.data_offset    = out_bus.data_offset;
    got.image_width    = out_bus.image_width;
    got.image_height   = out_bus.image_height;
    got.bits_per_pixel = out_bus.bits_per_pixel;
    got.red            = out_bus.red;
    got.green          = out_bus.green;
    got.blue           = out_bus.blue;
    got.run_end        = out_bus.run_end;
    if (exp_results.size() == 0) begin
      $display("%0t: result with kind %0d arrived with nothing pending", $realtime, got.kind);
      err_count++;
    end else begin
      want = exp_results.pop_front();
      report_mismatch("kind", {30'd0, got.kind}, {30'd0, want.kind});
      report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
      report_mismatch("file_size", got.file_size, want.file_size);
      report_mismatch("data_offset", got.data_offset, want.data_offset);
      report_mismatch("image_width", got.image_width, want.image_width);
      report_mismatch("image_height", got.image_height, want.image_height);
      report_mismatch("bits_per_pixel", {16'd0, got.bits_per_pixel},
                      {16'd0, want.bits_per_pixel});
      report_mismatch("red", {24'd0, got.red}, {24'd0, want.red});
      report_mismatch("green", {24'd0, got.green}, {24'd0, want.green});
      report_mismatch("blue", {24'd0, got.blue}, {24'd0, want.blue});
      report_mismatch("run_end", {31'd0, got.run_end}, {31'd0, want.run_end});
    end
  endtask

  // Sample both handshakes, check results, then predict from the accepted byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    = 1'b0;
      out_taken   = 1'b0;
      idle_cycles = 0;
      err_count   = 0;
      clear_parser();
    end else begin
      in_taken  = in_bus.valid && in_bus.ready;
      out_taken = out_bus.valid && out_bus.ready;
      if (out_taken) check_result();
      if (in_taken) parse_byte(in_bus.data_byte, in_bus.final_byte);
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.data_byte  <= 8'h00;
      in_bus.final_byte <= 1'b0;
      out_bus.ready     <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
      if (!in_bus.valid || in_taken) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_req = pend_q.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.data_byte  <= drv_req.data;
          in_bus.final_byte <= drv_req.fin;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic set_word(input int at, input logic [31:0] v, input int nbytes);
    for (int k = 0; k < nbytes; k++) file_buf[at + k] = v[8 * k +: 8];
  endtask

  // Fill file_buf with random bytes and place the header fields
  task automatic build_file(input int len, input logic [31:0] off, input logic [31:0] wid,
                            input logic [31:0] hgt);
    file_buf.delete();
    repeat (len) file_buf.insert(file_buf.size(), 8'($urandom));
    if (len >= 54) begin
      set_word(2, $urandom, 4);
      set_word(10, off, 4);
      set_word(18, wid, 4);
      set_word(22, hgt, 4);
      set_word(28, 32'($urandom_range(65535)), 2);
    end
  endtask

  task automatic flush_file();
    foreach (file_buf[i]) begin
      pend_q.insert(pend_q.size(),
                    byte_req_t'{data: file_buf[i], fin: (i == file_buf.size() - 1)});
    end
    bytes_queued += file_buf.size();
  endtask

  task automatic make_file();
    int          pick;
    int          len;
    int          body;
    int          rows;
    int          row_bytes;
    logic [31:0] off;
    logic [31:0] wid;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // truncated before the header ends
      file_buf.delete();
      len = $urandom_range(1, 53);
      repeat (len) file_buf.insert(file_buf.size(), 8'($urandom));
    end else if (pick < 16) begin
      build_file(54 + $urandom_range(12), $urandom_range(53), $urandom_range(4),
                 $urandom_range(4));
    end else if (pick < 23) begin
      // pixel data would start past the end of the file
      len = 54 + $urandom_range(20);
      off = $urandom_range(1) ? ($urandom | 32'h8000_0000) : 32'(len + $urandom_range(8));
      build_file(len, off, $urandom_range(1, 4), $urandom_range(4));
    end else if (pick < 28) begin
      build_file($urandom_range(54, 100), $urandom, $urandom, $urandom);
    end else begin
      off = 32'd54 + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
      if ($urandom_range(9) == 0) begin
        wid  = $urandom;
        body = $urandom_range(24);
      end else begin
        wid       = $urandom_range(5);
        rows      = $urandom_range(3);
        row_bytes = ((int'(wid) * 3 + 3) / 4) * 4;
        body      = (wid == 0) ? $urandom_range(24) : row_bytes * rows + $urandom_range(5);
      end
      build_file(int'(off) + body, off, wid, $urandom_range(3));
    end
    flush_file();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_bus.valid || exp_results.size() != 0);
  endtask

  initial begin
    int seg_start;
    rst_n        = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    bytes_queued = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // single zero byte, then a file one byte short of a header
    file_buf.delete();
    file_buf.insert(file_buf.size(), 8'h00);
    flush_file();
    file_buf.delete();
    repeat (53) file_buf.insert(file_buf.size(), 8'hff);
    flush_file();
    // header-only file: header and status from the same byte
    build_file(54, 32'd54, 32'hffff_ffff, 32'hffff_ffff);
    flush_file();
    // offset inside the header
    build_file(60, 32'd53, 32'd1, 32'd1);
    flush_file();
    // width 1: one padding byte per row, stream ends on a red byte
    build_file(61, 32'd54, 32'd1, 32'd1);
    flush_file();
    // zero width with a partial trailing pixel
    build_file(61, 32'd54, 32'd0, 32'd0);
    flush_file();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      // hold off until every pending result is back
      wait_drained();
      @(posedge clk);
      idle_pct  = IDLE_PCT[seg % 4];
      stall_pct = STALL_PCT[seg % 4];
      seg_start = bytes_queued;
      while (bytes_queued - seg_start < SEGMENT_BYTES) make_file();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
